// ===== hw/rtl/skip_count_task_scheduler_assert.svh =====
// Assertion macros used by the scheduler top level.
`ifndef SKIP_COUNT_TASK_SCHEDULER_ASSERT_SVH
`define SKIP_COUNT_TASK_SCHEDULER_ASSERT_SVH
// same-cycle implication, disabled in reset
`define SKCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skct check failed");
// next-cycle implication, disabled in reset
`define SKCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skct check failed");
`endif

// ===== hw/rtl/skct_pkg.sv =====
// Types and constants of the skip-count task scheduler.
package skct_pkg;
  localparam int TASK_SLOTS_DEF = 16;
  localparam logic [7:0] SKIP_MAX = 8'hFF;

  localparam logic [2:0] ST_INVALID = 3'd0;
  localparam logic [2:0] ST_UNRUN   = 3'd1;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_DELAYED = 3'd4;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_PICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_DELAY = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  task_index;
    logic [2:0]  task_state_in;
    logic [3:0]  task_priority_in;
    logic [31:0] delay_ticks;
  } cmd_t;

  typedef struct packed {
    logic [3:0] next_task;
    logic       none_runnable;
    logic       first_run;
  } result_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [3:0]  priority_lvl;
    logic [7:0]  skips;
    logic [31:0] delay;
  } slot_t;

  typedef enum logic [2:0] {
    HA_PASS, HA_TICK, HA_WRITE, HA_DELAY, HA_SCAN
  } head_act_t;

  typedef struct packed {
    head_act_t   action;
    logic        match;
    logic [2:0]  wr_state;
    logic [3:0]  wr_prio;
    logic [31:0] delay_ticks;
  } head_ctl_t;

  typedef struct packed {
    logic runnable;
    logic take;
    logic first;
  } head_sts_t;
endpackage

// ===== hw/rtl/skct_cell.sv =====
// One task slot record in the rotating ring.
module skct_cell
  import skct_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t rec_in,
  output slot_t rec
);
  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '{state: ST_INVALID, priority_lvl: 4'd0, skips: 8'd0, delay: 32'd0};
    end else if (shift) begin
      rec <= rec_in;
    end
  end
endmodule

// ===== hw/rtl/skct_head.sv =====
// Update logic applied to the slot leaving the head of the ring.
module skct_head
  import skct_pkg::*;
(
  input  slot_t     rec_in,
  input  head_ctl_t ctl,
  output slot_t     rec_out,
  output head_sts_t sts
);
  always_comb begin
    rec_out      = rec_in;
    sts.runnable = (rec_in.state == ST_UNRUN) || (rec_in.state == ST_READY);
    sts.take     = 1'b0;
    sts.first    = 1'b0;
    case (ctl.action)
      HA_TICK: begin
        if (rec_in.state == ST_DELAYED) begin
          if (rec_in.delay == 32'd0) rec_out.state = ST_READY;
          else rec_out.delay = rec_in.delay - 32'd1;
        end
      end
      HA_WRITE: begin
        if (ctl.match) begin
          rec_out.state        = (ctl.wr_state <= ST_DELAYED) ? ctl.wr_state : ST_INVALID;
          rec_out.priority_lvl = ctl.wr_prio;
          rec_out.skips        = 8'd0;
          rec_out.delay        = 32'd0;
        end
      end
      HA_DELAY: begin
        if (ctl.match) begin
          rec_out.state = ST_DELAYED;
          rec_out.delay = ctl.delay_ticks;
        end
      end
      HA_SCAN: begin
        if (rec_in.state == ST_UNRUN) begin
          rec_out.state = ST_READY;
          sts.take      = 1'b1;
          sts.first     = 1'b1;
        end else if (rec_in.state == ST_READY &&
                     rec_in.skips >= {4'd0, rec_in.priority_lvl}) begin
          rec_out.skips = 8'd0;
          sts.take      = 1'b1;
        end else if (rec_in.skips != SKIP_MAX) begin
          rec_out.skips = rec_in.skips + 8'd1;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/skip_count_task_scheduler.sv =====
// Top level: slot ring, head update and operation sequencer.
// Tick, slot write and delay pass every slot through the head once, one ring turn, then raise done.
// A pick first checks every slot for a runnable one, then rotates the ring to current+1 and scans,
// advancing skip counts until a slot is taken; with no runnable slot it ends after the check.
// One item at a time; busy stays high until the done beat, which cannot be stalled.
// Synchronous reset clears all slots to invalid and sets the current task to the last slot.
module skip_count_task_scheduler
  import skct_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);
  `include "skip_count_task_scheduler_assert.svh"

  localparam int IW = $clog2(TASK_SLOTS);
  localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

  typedef enum logic [2:0] {S_IDLE, S_ANY, S_SEEK, S_SCAN, S_SWEEP} seq_t;

  seq_t          state;
  cmd_t          cmd_q;
  logic [IW-1:0] cur;
  logic [IW-1:0] head_idx;
  logic [IW-1:0] cnt;
  logic          any_acc;

  slot_t     ring [TASK_SLOTS];
  slot_t     head_out;
  head_ctl_t ctl;
  head_sts_t sts;
  logic      shift;
  logic [IW+3:0] cur_ext, head_ext;

  assign shift = (state != S_IDLE);
  assign busy  = (state != S_IDLE);
  assign cur_ext  = {4'd0, cur};
  assign head_ext = {4'd0, head_idx};

  genvar g;
  generate
    for (g = 0; g < TASK_SLOTS; g++) begin : g_cell
      if (g == TASK_SLOTS - 1) begin : g_tail
        skct_cell u_cell (.clk, .rst, .shift, .rec_in(head_out), .rec(ring[g]));
      end else begin : g_mid
        skct_cell u_cell (.clk, .rst, .shift, .rec_in(ring[g+1]), .rec(ring[g]));
      end
    end
  endgenerate

  always_comb begin
    ctl.action      = HA_PASS;
    ctl.match       = 1'b0;
    ctl.wr_state    = cmd_q.task_state_in;
    ctl.wr_prio     = cmd_q.task_priority_in;
    ctl.delay_ticks = cmd_q.delay_ticks;
    case (state)
      S_SCAN: ctl.action = HA_SCAN;
      S_SWEEP: begin
        case (cmd_q.operation)
          OP_TICK: ctl.action = HA_TICK;
          OP_WRITE: begin
            ctl.action = HA_WRITE;
            ctl.match  = (head_ext == {{IW{1'b0}}, cmd_q.task_index});
          end
          OP_DELAY: begin
            ctl.action = HA_DELAY;
            ctl.match  = (head_idx == cur);
          end
          default: ctl.action = HA_PASS;
        endcase
      end
      default: ctl.action = HA_PASS;
    endcase
  end

  skct_head u_head (.rec_in(ring[0]), .ctl, .rec_out(head_out), .sts);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur      <= LAST;
      head_idx <= '0;
      cnt      <= '0;
      any_acc  <= 1'b0;
      done     <= 1'b0;
      result   <= '0;
      cmd_q    <= '0;
    end else begin
      done <= 1'b0;
      if (shift) head_idx <= (head_idx == LAST) ? '0 : head_idx + IW'(1);
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd;
            cnt     <= '0;
            any_acc <= 1'b0;
            state   <= (cmd.operation == OP_PICK) ? S_ANY : S_SWEEP;
          end
        end
        S_ANY: begin
          any_acc <= any_acc | sts.runnable;
          cnt     <= cnt + IW'(1);
          if (cnt == LAST) begin
            if (any_acc || sts.runnable) begin
              state <= S_SEEK;
            end else begin
              state  <= S_IDLE;
              done   <= 1'b1;
              result <= '{next_task: cur_ext[3:0], none_runnable: 1'b1, first_run: 1'b0};
            end
          end
        end
        S_SEEK: begin
          if (head_idx == cur) state <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.take) begin
            cur    <= head_idx;
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '{next_task: head_ext[3:0], none_runnable: 1'b0, first_run: sts.first};
          end
        end
        S_SWEEP: begin
          cnt <= cnt + IW'(1);
          if (cnt == LAST) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            result <= '{next_task: cur_ext[3:0], none_runnable: 1'b0, first_run: 1'b0};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SKCT_ASSERT_IMP(a_done_idle, done, !busy)
  `SKCT_ASSERT_NXT(a_start_busy, start && !busy, busy || done)
  `SKCT_ASSERT_IMP(a_none_not_first, done && result.none_runnable, !result.first_run)
  `SKCT_ASSERT_IMP(a_cur_range, 1'b1, cur_ext <= (IW+4)'(TASK_SLOTS - 1))
endmodule
